// File: rtl/lut_linear_interpolator_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the lookup interpolator.
// ----------------------------------------------------------------------------
`ifndef LUT_LINEAR_INTERPOLATOR_TOP_DEFINES_SVH
`define LUT_LINEAR_INTERPOLATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LLI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lli assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define LLI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lli assertion failed");

`endif

// File: rtl/lli_pkg.sv
// ----------------------------------------------------------------------------
// lli_pkg
// Types, widths and constants of the lookup table interpolator.
// ----------------------------------------------------------------------------
package lli_pkg;

    localparam int FORCE_W   = 24;
    localparam int POS_W     = 17;
    localparam int FRAC_W    = 16;
    localparam int INDEX_W   = 7;
    localparam int THR_W     = 16;
    localparam int SEG_CNT_W = 7;
    localparam int SCALED_W  = FRAC_W + SEG_CNT_W;

    localparam int DAMPING_SEGMENTS_DEF = 16;
    localparam int SPRING_SEGMENTS_DEF  = 16;

    localparam logic [FRAC_W-1:0] POS_TOP       = 16'd65470;
    localparam logic [THR_W-1:0]  THRESH_RESET  = 16'd66;

    typedef enum logic [1:0] {
        FUNC_EVAL_DAMP    = 2'd0,
        FUNC_EVAL_SPRING  = 2'd1,
        FUNC_WRITE_DAMP   = 2'd2,
        FUNC_WRITE_SPRING = 2'd3
    } func_t;

    typedef struct packed {
        logic                       spring;
        logic                       is_write;
        logic                       zero;
        logic                       top;
        logic [SCALED_W-1:0]        scaled;
        logic [INDEX_W-1:0]         entry_index;
        logic signed [FORCE_W-1:0]  entry_value;
    } front_t;

    typedef struct packed {
        logic              spring;
        logic              zero;
        logic [FRAC_W-1:0] frac;
    } lookup_t;

endpackage

// File: rtl/lli_req_if.sv
// ----------------------------------------------------------------------------
// lli_req_if
// Request channel: evaluate and table write requests.
// ----------------------------------------------------------------------------
interface lli_req_if;
    import lli_pkg::*;

    logic                      valid;
    logic                      ready;
    func_t                     func;
    logic signed [POS_W-1:0]   position;
    logic [INDEX_W-1:0]        entry_index;
    logic signed [FORCE_W-1:0] entry_value;

    modport source (output valid, func, position, entry_index, entry_value, input ready);
    modport sink   (input valid, func, position, entry_index, entry_value, output ready);
endinterface

// File: rtl/lli_res_if.sv
// ----------------------------------------------------------------------------
// lli_res_if
// Result channel: interpolated force.
// ----------------------------------------------------------------------------
interface lli_res_if;
    import lli_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [FORCE_W-1:0] force_res;
    logic                      from_spring;

    modport source (output valid, force_res, from_spring, input ready);
    modport sink   (input valid, force_res, from_spring, output ready);
endinterface

// File: rtl/lli_cfg_if.sv
// ----------------------------------------------------------------------------
// lli_cfg_if
// Configuration write channel for the springing threshold.
// ----------------------------------------------------------------------------
interface lli_cfg_if;
    import lli_pkg::*;

    logic             valid;
    logic             ready;
    logic [THR_W-1:0] spring_low_threshold;

    modport source (output valid, spring_low_threshold, input ready);
    modport sink   (input valid, spring_low_threshold, output ready);
endinterface

// File: rtl/lli_ram.sv
// ----------------------------------------------------------------------------
// lli_ram
// Generic RAM, one write port, two registered read ports.
// ----------------------------------------------------------------------------
module lli_ram #(
    parameter int WIDTH = lli_pkg::FORCE_W,
    parameter int DEPTH = lli_pkg::DAMPING_SEGMENTS_DEF + 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;
endmodule

// File: rtl/lli_front.sv
// ----------------------------------------------------------------------------
// lli_front
// Stage 1: decode request, range checks, scale position by segment count.
// ----------------------------------------------------------------------------
module lli_front #(
    parameter int DAMP_SEGS   = lli_pkg::DAMPING_SEGMENTS_DEF,
    parameter int SPRING_SEGS = lli_pkg::SPRING_SEGMENTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  lli_pkg::func_t                     func,
    input  logic signed [lli_pkg::POS_W-1:0]   position,
    input  logic [lli_pkg::INDEX_W-1:0]        entry_index,
    input  logic signed [lli_pkg::FORCE_W-1:0] entry_value,
    input  logic [lli_pkg::THR_W-1:0]          threshold,
    output logic                               out_valid,
    input  logic                               out_ready,
    output lli_pkg::front_t                    out_data
);
    import lli_pkg::*;

    logic                 valid_reg;
    front_t               data_reg;
    front_t               data_next;
    logic                 advance;
    logic [SEG_CNT_W-1:0] segs;

    assign in_ready = !valid_reg || out_ready;
    assign advance  = in_valid && in_ready;

    always_comb
    begin
        unique case (func)
            FUNC_EVAL_DAMP:
            begin
                data_next.spring   = 1'b0;
                data_next.is_write = 1'b0;
            end
            FUNC_EVAL_SPRING:
            begin
                data_next.spring   = 1'b1;
                data_next.is_write = 1'b0;
            end
            FUNC_WRITE_DAMP:
            begin
                data_next.spring   = 1'b0;
                data_next.is_write = 1'b1;
            end
            FUNC_WRITE_SPRING:
            begin
                data_next.spring   = 1'b1;
                data_next.is_write = 1'b1;
            end
        endcase
        segs = data_next.spring ? SEG_CNT_W'(SPRING_SEGS) : SEG_CNT_W'(DAMP_SEGS);
        data_next.zero = data_next.spring
                       ? ($signed(position) < $signed({1'b0, threshold}))
                       : position[POS_W-1];
        data_next.top  = !position[POS_W-1] && (position[FRAC_W-1:0] > POS_TOP);
        data_next.scaled      = SCALED_W'(position[FRAC_W-1:0]) * SCALED_W'(segs);
        data_next.entry_index = entry_index;
        data_next.entry_value = entry_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

// File: rtl/lli_lookup.sv
// ----------------------------------------------------------------------------
// lli_lookup
// Stage 2: segment address, table writes, neighbor entry reads.
// ----------------------------------------------------------------------------
module lli_lookup #(
    parameter int DAMP_SEGS   = lli_pkg::DAMPING_SEGMENTS_DEF,
    parameter int SPRING_SEGS = lli_pkg::SPRING_SEGMENTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  lli_pkg::front_t                    in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output lli_pkg::lookup_t                   out_data,
    output logic signed [lli_pkg::FORCE_W-1:0] ta,
    output logic signed [lli_pkg::FORCE_W-1:0] tb
);
    import lli_pkg::*;

    localparam int DAW = $clog2(DAMP_SEGS + 1);
    localparam int SAW = $clog2(SPRING_SEGS + 1);

    logic                 valid_reg;
    lookup_t              data_reg;
    lookup_t              data_next;
    logic                 advance;
    logic [SEG_CNT_W-1:0] seg_idx;
    logic [SEG_CNT_W-1:0] idx_d;
    logic [SEG_CNT_W-1:0] idx_s;
    logic [DAW-1:0]       addr_a_d;
    logic [DAW-1:0]       addr_b_d;
    logic [SAW-1:0]       addr_a_s;
    logic [SAW-1:0]       addr_b_s;
    logic                 we_d;
    logic                 we_s;
    logic                 re_d;
    logic                 re_s;
    logic [FORCE_W-1:0]   rd_a_d;
    logic [FORCE_W-1:0]   rd_b_d;
    logic [FORCE_W-1:0]   rd_a_s;
    logic [FORCE_W-1:0]   rd_b_s;

    assign in_ready = !valid_reg || out_ready;
    assign advance  = in_valid && in_ready;

    always_comb
    begin
        seg_idx = in_data.scaled[SCALED_W-1:FRAC_W];
        idx_d   = (seg_idx >= SEG_CNT_W'(DAMP_SEGS)) ? SEG_CNT_W'(DAMP_SEGS - 1) : seg_idx;
        idx_s   = (seg_idx >= SEG_CNT_W'(SPRING_SEGS)) ? SEG_CNT_W'(SPRING_SEGS - 1) : seg_idx;
        addr_a_d = in_data.top ? DAW'(DAMP_SEGS) : DAW'(idx_d);
        addr_b_d = in_data.top ? DAW'(DAMP_SEGS) : DAW'(idx_d + 1'b1);
        addr_a_s = in_data.top ? SAW'(SPRING_SEGS) : SAW'(idx_s);
        addr_b_s = in_data.top ? SAW'(SPRING_SEGS) : SAW'(idx_s + 1'b1);
        we_d = advance && in_data.is_write && !in_data.spring
            && (in_data.entry_index <= INDEX_W'(DAMP_SEGS));
        we_s = advance && in_data.is_write && in_data.spring
            && (in_data.entry_index <= INDEX_W'(SPRING_SEGS));
        re_d = advance && !in_data.is_write && !in_data.spring;
        re_s = advance && !in_data.is_write && in_data.spring;
        data_next.spring = in_data.spring;
        data_next.zero   = in_data.zero;
        data_next.frac   = in_data.top ? '0 : in_data.scaled[FRAC_W-1:0];
    end

    lli_ram #(
        .WIDTH (FORCE_W),
        .DEPTH (DAMP_SEGS + 1)
    ) u_damp_ram (
        .clk     (clk),
        .we      (we_d),
        .waddr   (DAW'(in_data.entry_index)),
        .wdata   (in_data.entry_value),
        .re      (re_d),
        .raddr_a (addr_a_d),
        .raddr_b (addr_b_d),
        .rdata_a (rd_a_d),
        .rdata_b (rd_b_d)
    );

    lli_ram #(
        .WIDTH (FORCE_W),
        .DEPTH (SPRING_SEGS + 1)
    ) u_spring_ram (
        .clk     (clk),
        .we      (we_s),
        .waddr   (SAW'(in_data.entry_index)),
        .wdata   (in_data.entry_value),
        .re      (re_s),
        .raddr_a (addr_a_s),
        .raddr_b (addr_b_s),
        .rdata_a (rd_a_s),
        .rdata_b (rd_b_s)
    );

    // drop write requests here: they carry no result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid && !in_data.is_write;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign ta = data_reg.spring ? $signed(rd_a_s) : $signed(rd_a_d);
    assign tb = data_reg.spring ? $signed(rd_b_s) : $signed(rd_b_d);

    `include "lut_linear_interpolator_top_defines.svh"

    `LLI_ASSERT_NEXT(a_write_no_result, advance && in_data.is_write, !valid_reg)
    `LLI_ASSERT_NEXT(a_top_frac_zero, advance && in_data.top, data_reg.frac == '0)
    `LLI_ASSERT_NOW(a_port_exclusive, 1'b1, !(we_d && re_d) && !(we_s && re_s))
endmodule

// File: rtl/lli_blend.sv
// ----------------------------------------------------------------------------
// lli_blend
// Stages 3 and 4: weighted products, rounding sum, saturation.
// ----------------------------------------------------------------------------
module lli_blend (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  lli_pkg::lookup_t                   in_data,
    input  logic signed [lli_pkg::FORCE_W-1:0] ta,
    input  logic signed [lli_pkg::FORCE_W-1:0] tb,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [lli_pkg::FORCE_W-1:0] force_res,
    output logic                               from_spring
);
    import lli_pkg::*;

    localparam int WEIGHT_W = FRAC_W + 1;
    localparam int PROD_W   = FORCE_W + WEIGHT_W + 1;
    localparam int SUM_W    = PROD_W + 1;
    localparam int QW       = SUM_W - FRAC_W;
    localparam int ROUND_HALF = 2 ** (FRAC_W - 1);
    localparam logic signed [QW-1:0] Q_MAX = QW'(2 ** (FORCE_W - 1) - 1);
    localparam logic signed [QW-1:0] Q_MIN = QW'(-(2 ** (FORCE_W - 1)));

    logic                      p_valid_reg;
    logic signed [PROD_W-1:0]  prod_a_reg;
    logic signed [PROD_W-1:0]  prod_b_reg;
    logic signed [PROD_W-1:0]  prod_a_next;
    logic signed [PROD_W-1:0]  prod_b_next;
    logic                      zero_reg;
    logic                      spring_reg;
    logic [WEIGHT_W-1:0]       weight_a;
    logic signed [WEIGHT_W:0]  weight_a_s;
    logic signed [WEIGHT_W:0]  weight_b_s;
    logic                      adv_p;
    logic                      out_open;
    logic                      adv_o;
    logic signed [SUM_W-1:0]   sum;
    logic signed [QW-1:0]      quot;
    logic signed [FORCE_W-1:0] force_next;
    logic                      o_valid_reg;
    logic signed [FORCE_W-1:0] force_reg;
    logic                      from_spring_reg;

    assign out_open = !o_valid_reg || out_ready;
    assign in_ready = !p_valid_reg || out_open;
    assign adv_p    = in_valid && in_ready;
    assign adv_o    = p_valid_reg && out_open;

    always_comb
    begin
        weight_a    = WEIGHT_W'(2 ** FRAC_W) - {1'b0, in_data.frac};
        weight_a_s  = {1'b0, weight_a};
        weight_b_s  = {2'b00, in_data.frac};
        prod_a_next = ta * weight_a_s;
        prod_b_next = tb * weight_b_s;
    end

    always_comb
    begin
        sum  = SUM_W'(prod_a_reg) + SUM_W'(prod_b_reg) + SUM_W'(ROUND_HALF);
        quot = sum[SUM_W-1:FRAC_W];
        if (zero_reg)
        begin
            force_next = '0;
        end
        else if (quot > Q_MAX)
        begin
            force_next = Q_MAX[FORCE_W-1:0];
        end
        else if (quot < Q_MIN)
        begin
            force_next = Q_MIN[FORCE_W-1:0];
        end
        else
        begin
            force_next = quot[FORCE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                p_valid_reg <= in_valid;
            end
            if (out_open)
            begin
                o_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_p)
        begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
            zero_reg   <= in_data.zero;
            spring_reg <= in_data.spring;
        end
        if (adv_o)
        begin
            force_reg       <= force_next;
            from_spring_reg <= spring_reg;
        end
    end

    assign out_valid   = o_valid_reg;
    assign force_res   = force_reg;
    assign from_spring = from_spring_reg;

    `include "lut_linear_interpolator_top_defines.svh"

    `LLI_ASSERT_NEXT(a_zero_gives_zero, adv_o && zero_reg, force_reg == '0)
    `LLI_ASSERT_NEXT(a_table_tag_kept, adv_o, from_spring_reg == $past(spring_reg))
    `LLI_ASSERT_NEXT(a_frac_zero_weight, adv_p && (in_data.frac == '0), prod_b_reg == '0)
endmodule

// File: rtl/lut_linear_interpolator_top.sv
// ----------------------------------------------------------------------------
// lut_linear_interpolator_top
// Piecewise linear force lookup over loadable damping and springing tables.
//
//   channel  dir  contents
//   req      in   func, position, entry_index, entry_value
//   res      out  force_res, from_spring (one per evaluate request)
//   cfg      in   spring_low_threshold
//
// One request per cycle while no stage is stalled; a result passes through the
// front, lookup, product and output registers after its request is accepted.
// The stages are: decode and scale multiply, table read, weight multiply,
// round and saturate. Each stage stalls on its own, so bubbles fill in.
// Reset clears valid bits and sets the threshold to 66; table contents are
// undefined until written and there is no clearing pass.
// ----------------------------------------------------------------------------
module lut_linear_interpolator_top #(
    parameter int DAMPING_SEGMENTS = lli_pkg::DAMPING_SEGMENTS_DEF,
    parameter int SPRING_SEGMENTS  = lli_pkg::SPRING_SEGMENTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    lli_req_if.sink     req,
    lli_res_if.source   res,
    lli_cfg_if.sink     cfg
);
    import lli_pkg::*;

    logic [THR_W-1:0]          thr_reg;
    logic                      f_valid;
    logic                      f_ready;
    front_t                    f_data;
    logic                      l_valid;
    logic                      l_ready;
    lookup_t                   l_data;
    logic signed [FORCE_W-1:0] ta;
    logic signed [FORCE_W-1:0] tb;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESH_RESET;
        end
        else if (cfg.valid)
        begin
            thr_reg <= cfg.spring_low_threshold;
        end
    end

    lli_front #(
        .DAMP_SEGS   (DAMPING_SEGMENTS),
        .SPRING_SEGS (SPRING_SEGMENTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_ready    (req.ready),
        .func        (req.func),
        .position    (req.position),
        .entry_index (req.entry_index),
        .entry_value (req.entry_value),
        .threshold   (thr_reg),
        .out_valid   (f_valid),
        .out_ready   (f_ready),
        .out_data    (f_data)
    );

    lli_lookup #(
        .DAMP_SEGS   (DAMPING_SEGMENTS),
        .SPRING_SEGS (SPRING_SEGMENTS)
    ) u_lookup (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (l_valid),
        .out_ready (l_ready),
        .out_data  (l_data),
        .ta        (ta),
        .tb        (tb)
    );

    lli_blend u_blend (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (l_valid),
        .in_ready    (l_ready),
        .in_data     (l_data),
        .ta          (ta),
        .tb          (tb),
        .out_valid   (res.valid),
        .out_ready   (res.ready),
        .force_res   (res.force_res),
        .from_spring (res.from_spring)
    );
endmodule

// File: dv/lut_linear_interpolator_top_test.sv
// ----------------------------------------------------------------------------
// lut_linear_interpolator_top_test
// Self-checking bench for the lookup table interpolator. A directed table
// loads the table ends and probes zero regions, the top clamp and ignored
// writes. Random phases then reload both tables, change the springing
// threshold while idle, and mix writes with evaluations, mostly under random
// sender gaps and receiver stalls. Each result is checked against its listed
// force for typed directed rows, else against a local blend model.
// ----------------------------------------------------------------------------
module lut_linear_interpolator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lli_pkg::*;

    localparam int DAMP_SEGS    = DAMPING_SEGMENTS_DEF;
    localparam int SPRING_SEGS  = SPRING_SEGMENTS_DEF;
    localparam int DRAIN_CYCLES = 12;
    localparam int LONG_HOLD    = 150;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DIR_N        = 24;

    localparam logic signed [FORCE_W-1:0] FORCE_MAX = 24'sh7FFFFF;
    localparam logic signed [FORCE_W-1:0] FORCE_MIN = 24'sh800000;

    typedef struct packed {
        logic signed [FORCE_W-1:0] force_val;
        logic                      spring;
    } force_exp_t;

    typedef struct packed {
        func_t                     func;
        logic signed [POS_W-1:0]   pos;
        logic [INDEX_W-1:0]        idx;
        logic signed [FORCE_W-1:0] val;
        logic                      typed;
        logic signed [FORCE_W-1:0] force_val;
    } dir_row_t;

    localparam dir_row_t DIRECTED [DIR_N] = '{
        '{FUNC_WRITE_DAMP,     0,   0, FORCE_MAX, 1'b0, 0},
        '{FUNC_WRITE_DAMP,     0,   1, FORCE_MIN, 1'b0, 0},
        '{FUNC_WRITE_DAMP,     0,  15, 1000,      1'b0, 0},
        '{FUNC_WRITE_DAMP,     0,  16, -2000,     1'b0, 0},
        '{FUNC_WRITE_SPRING,   0,   0, FORCE_MIN, 1'b0, 0},
        '{FUNC_WRITE_SPRING,   0,   1, FORCE_MAX, 1'b0, 0},
        '{FUNC_WRITE_SPRING,   0,  15, 123456,    1'b0, 0},
        '{FUNC_WRITE_SPRING,   0,  16, -7,        1'b0, 0},
        '{FUNC_WRITE_DAMP,     0,  17, 555,       1'b0, 0},
        '{FUNC_WRITE_SPRING,   0, 127, 999,       1'b0, 0},
        '{FUNC_EVAL_DAMP,      0,   0, 0,         1'b1, FORCE_MAX},
        '{FUNC_EVAL_DAMP,     -1,   0, 0,         1'b1, 0},
        '{FUNC_EVAL_DAMP, -65536,   0, 0,         1'b1, 0},
        '{FUNC_EVAL_DAMP,  65535,   0, 0,         1'b1, -2000},
        '{FUNC_EVAL_DAMP,  65471,   0, 0,         1'b1, -2000},
        '{FUNC_EVAL_DAMP,  65470,   0, 0,         1'b0, 0},
        '{FUNC_EVAL_DAMP,   2048,   0, 0,         1'b0, 0},
        '{FUNC_EVAL_SPRING,   65,   0, 0,         1'b1, 0},
        '{FUNC_EVAL_SPRING, -65536, 0, 0,         1'b1, 0},
        '{FUNC_EVAL_SPRING,   66,   0, 0,         1'b0, 0},
        '{FUNC_EVAL_SPRING, 65535,  0, 0,         1'b1, -7},
        '{FUNC_EVAL_SPRING, 65471,  0, 0,         1'b1, -7},
        '{FUNC_EVAL_SPRING,  4095,  0, 0,         1'b0, 0},
        '{FUNC_EVAL_SPRING, 61440,  0, 0,         1'b1, 123456}
    };

    logic clk;
    logic rst_n;

    lli_req_if req_if ();
    lli_res_if res_if ();
    lli_cfg_if cfg_if ();

    lut_linear_interpolator_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    logic signed [FORCE_W-1:0] damp_lut   [0:DAMP_SEGS];
    logic signed [FORCE_W-1:0] spring_lut [0:SPRING_SEGS];
    logic [THR_W-1:0]          spring_thr;
    force_exp_t                force_q [$];

    bit idle_en;
    bit stall_en;
    bit hold_req;
    int err_cnt;
    int eval_cnt;
    int write_cnt;
    int cfg_cnt;
    int checked_cnt;
    int cycle_cnt;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [FORCE_W-1:0] lut_blend(input bit spring, input int pos);
        int          seg_cnt;
        int unsigned scaled;
        int unsigned seg;
        longint      frac;
        longint      lo_v;
        longint      hi_v;
        longint      acc;
        seg_cnt = spring ? SPRING_SEGS : DAMP_SEGS;
        if (pos > int'(POS_TOP))
            return spring ? spring_lut[seg_cnt] : damp_lut[seg_cnt];
        scaled = pos * seg_cnt;
        seg    = scaled >> FRAC_W;
        frac   = longint'(scaled & 32'hFFFF);
        if (seg >= seg_cnt)
            seg = seg_cnt - 1;
        lo_v = longint'(spring ? spring_lut[seg] : damp_lut[seg]);
        hi_v = longint'(spring ? spring_lut[seg + 1] : damp_lut[seg + 1]);
        acc  = lo_v * (65536 - frac) + hi_v * frac + 32768;
        acc  = acc >>> FRAC_W;
        if (acc > longint'(FORCE_MAX))
            acc = longint'(FORCE_MAX);
        if (acc < longint'(FORCE_MIN))
            acc = longint'(FORCE_MIN);
        return acc[FORCE_W-1:0];
    endfunction

    function automatic force_exp_t predict_force(input func_t f, input logic signed [POS_W-1:0] pos);
        force_exp_t e;
        int         p;
        p        = int'(pos);
        e.spring = (f == FUNC_EVAL_SPRING);
        if (e.spring)
            e.force_val = (p < int'(spring_thr)) ? '0 : lut_blend(1'b1, p);
        else
            e.force_val = (p < 0) ? '0 : lut_blend(1'b0, p);
        return e;
    endfunction

    task automatic put_request(input func_t f, input logic signed [POS_W-1:0] pos,
                               input logic [INDEX_W-1:0] idx,
                               input logic signed [FORCE_W-1:0] val,
                               input bit typed, input logic signed [FORCE_W-1:0] typed_force);
        force_exp_t e;
        req_if.valid       <= 1'b1;
        req_if.func        <= f;
        req_if.position    <= pos;
        req_if.entry_index <= idx;
        req_if.entry_value <= val;
        do @(posedge clk); while (!req_if.ready);
        case (f)
            FUNC_EVAL_DAMP, FUNC_EVAL_SPRING:
            begin
                e = predict_force(f, pos);
                if (typed)
                    e.force_val = typed_force;
                force_q.push_back(e);
                eval_cnt++;
            end
            FUNC_WRITE_DAMP:
            begin
                if (idx <= DAMP_SEGS)
                    damp_lut[idx] = val;
                write_cnt++;
            end
            default:
            begin
                if (idx <= SPRING_SEGS)
                    spring_lut[idx] = val;
                write_cnt++;
            end
        endcase
        if (idle_en && $urandom_range(0, 7) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        while (force_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] thr);
        cfg_if.valid                <= 1'b1;
        cfg_if.spring_low_threshold <= thr;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        spring_thr = thr;
        cfg_cnt++;
    endtask

    function automatic logic signed [FORCE_W-1:0] rand_force();
        case ($urandom_range(0, 7))
            0:       return FORCE_MAX;
            1:       return FORCE_MIN;
            2:       return FORCE_W'($urandom_range(0, 255) - 128);
            default: return FORCE_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [POS_W-1:0] rand_position();
        int p;
        case ($urandom_range(0, 7))
            0:       p = $urandom_range(0, 32) - 16;
            1:       p = $urandom_range(65440, 65535);
            2:       p = int'(spring_thr) + $urandom_range(0, 4) - 2;
            3:       p = $urandom_range(0, 15) * 4096 + $urandom_range(0, 2) - 1;
            4:       p = -int'($urandom_range(1, 65536));
            default: p = $urandom_range(0, 65535);
        endcase
        return POS_W'(p);
    endfunction

    task automatic load_tables();
        for (int i = 0; i <= DAMP_SEGS; i++)
            put_request(FUNC_WRITE_DAMP, POS_W'($urandom), INDEX_W'(i), rand_force(),
                        1'b0, '0);
        for (int i = 0; i <= SPRING_SEGS; i++)
            put_request(FUNC_WRITE_SPRING, POS_W'($urandom), INDEX_W'(i), rand_force(),
                        1'b0, '0);
    endtask

    task automatic run_random(input int n);
        func_t             f;
        logic [INDEX_W-1:0] idx;
        for (int k = 0; k < n; k++)
        begin
            case ($urandom_range(0, 7))
                0:       f = FUNC_WRITE_DAMP;
                1:       f = FUNC_WRITE_SPRING;
                2, 3, 4: f = FUNC_EVAL_DAMP;
                default: f = FUNC_EVAL_SPRING;
            endcase
            if ($urandom_range(0, 7) == 0)
                idx = INDEX_W'($urandom_range(DAMP_SEGS + 1, 127));
            else
                idx = INDEX_W'($urandom_range(0, DAMP_SEGS));
            put_request(f, rand_position(), idx, rand_force(), 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin : check_result
        force_exp_t e;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (force_q.size() == 0)
            begin
                err_cnt++;
                $display("%0t: unexpected result force %0d spring %0b", $time,
                         res_if.force_res, res_if.from_spring);
            end
            else
            begin
                e = force_q.pop_front();
                checked_cnt++;
                if (res_if.force_res !== e.force_val)
                begin
                    err_cnt++;
                    $display("%0t: force_res expected %0d actual %0d", $time,
                             e.force_val, res_if.force_res);
                end
                if (res_if.from_spring !== e.spring)
                begin
                    err_cnt++;
                    $display("%0t: from_spring expected %0b actual %0b", $time,
                             e.spring, res_if.from_spring);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_cnt, force_q.size());
            $display("FAIL lut_linear_interpolator_top");
            $finish;
        end
    end

    initial
    begin
        res_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        res_if.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                res_if.ready <= 1'b1;
            end
            else if (stall_en && $urandom_range(0, 9) == 0)
            begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                res_if.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_if.valid                <= 1'b0;
        req_if.func                 <= FUNC_EVAL_DAMP;
        req_if.position             <= '0;
        req_if.entry_index          <= '0;
        req_if.entry_value          <= '0;
        cfg_if.valid                <= 1'b0;
        cfg_if.spring_low_threshold <= '0;
        spring_thr = THRESH_RESET;
        for (int i = 0; i <= DAMP_SEGS; i++)
            damp_lut[i] = '0;
        for (int i = 0; i <= SPRING_SEGS; i++)
            spring_lut[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_en  = 1'b1;
        stall_en = 1'b1;
        foreach (DIRECTED[i])
            put_request(DIRECTED[i].func, DIRECTED[i].pos, DIRECTED[i].idx, DIRECTED[i].val,
                        DIRECTED[i].typed, DIRECTED[i].force_val);
        load_tables();
        drain_results();

        write_threshold('0);
        hold_req = 1'b1;
        run_random(200);
        drain_results();

        write_threshold(16'hFFFF);
        run_random(150);
        drain_results();

        write_threshold(THR_W'($urandom));
        load_tables();
        run_random(200);
        drain_results();

        idle_en  = 1'b0;
        stall_en = 1'b0;
        write_threshold(THR_W'($urandom_range(0, 4096)));
        run_random(150);
        drain_results();

        $display("%0d evaluations checked (%0d results), %0d table writes, %0d threshold writes",
                 eval_cnt, checked_cnt, write_cnt, cfg_cnt);
        $display("%0d mismatches over %0d cycles", err_cnt, cycle_cnt);
        if (err_cnt == 0)
            $display("PASS lut_linear_interpolator_top");
        else
            $display("FAIL lut_linear_interpolator_top");
        $finish;
    end

endmodule
